FILE: hw/rtl/smps_pkg.sv
// Shared types and constants for the servo motion profile stepper.
`timescale 1ns / 1ps

package smps_pkg;

  // Field widths
  localparam int PW        = 26;  // position, velocity, acceleration, counts
  localparam int DIVW      = 10;  // pulse divisor
  localparam int CFG_IDX_W = 3;   // register index

  // Reset values
  localparam logic [PW-1:0]   POS_RESET   = 26'd1500000;
  localparam logic [PW-1:0]   LIMIT_RESET = 26'd65535;
  localparam logic [DIVW-1:0] DIV_RESET   = 10'd1;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_POS_GOAL    = 3'd1,
    REG_VEL_GOAL    = 3'd2,
    REG_ACCEL       = 3'd3,
    REG_VEL_LIMIT   = 3'd4,
    REG_ACCEL_LIMIT = 3'd5,
    REG_DIVISOR     = 3'd6
  } cfg_reg_t;

  // Motion settings handed to the update sequencer
  typedef struct packed {
    logic          enable;
    logic [PW-1:0] position_goal;
    logic [PW-1:0] velocity_goal;
    logic [PW-1:0] acceleration;
    logic [PW-1:0] velocity_limit;
    logic [PW-1:0] acceleration_limit;
  } motion_cfg_t;

  // Motion sequencer states
  typedef enum logic [1:0] {
    M_IDLE,
    M_POS,
    M_VEL
  } motion_state_t;

  // Top-level control states
  typedef enum logic [1:0] {
    T_IDLE,
    T_MOTION,
    T_DIV,
    T_LOAD
  } top_state_t;

endpackage

FILE: hw/rtl/smps_step_unit.sv
// Shared add-and-clamp unit: base plus or minus (x + y), clamped at a goal.
`timescale 1ns / 1ps

module smps_step_unit (
  input  logic [smps_pkg::PW-1:0] base,
  input  logic [smps_pkg::PW-1:0] x,
  input  logic [smps_pkg::PW-1:0] y,
  input  logic                    up,
  input  logic [smps_pkg::PW-1:0] goal,
  output logic [smps_pkg::PW-1:0] result
);
  import smps_pkg::*;

  logic [PW:0]          sum;
  logic signed [PW+2:0] base_ext;
  logic signed [PW+2:0] sum_ext;
  logic signed [PW+2:0] goal_ext;
  logic signed [PW+2:0] next;
  logic                 clamp;

  // Step magnitude and signed move
  always_comb begin
    sum      = {1'b0, x} + {1'b0, y};
    base_ext = $signed({3'b000, base});
    sum_ext  = $signed({2'b00, sum});
    goal_ext = $signed({3'b000, goal});
    next     = up ? (base_ext + sum_ext) : (base_ext - sum_ext);
  end

  // Stop at the goal on overshoot (signed, so below zero also stops)
  always_comb begin
    clamp  = up ? (next > goal_ext) : (next < goal_ext);
    result = clamp ? goal : next[PW-1:0];
  end

endmodule

FILE: hw/rtl/smps_motion.sv
// Position and velocity update sequencer around the shared step unit.
`timescale 1ns / 1ps

module smps_motion (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    period_ended,
  input  smps_pkg::motion_cfg_t   cfg,
  output logic                    done,
  output logic [smps_pkg::PW-1:0] position_ns,
  output logic [smps_pkg::PW-1:0] velocity_now,
  output logic                    pos_hit,
  output logic                    vel_hit
);
  import smps_pkg::*;

  motion_state_t state;
  motion_state_t state_next;
  logic          done_next;

  logic [PW-1:0] pos_new;
  logic          active;
  logic          accel_max;
  logic          bypass_pos;

  logic [PW-1:0] u_base;
  logic [PW-1:0] u_x;
  logic [PW-1:0] u_y;
  logic          u_up;
  logic [PW-1:0] u_goal;
  logic [PW-1:0] u_result;

  logic [PW-1:0] vel_upd;
  logic          vhit;

  // Update conditions
  always_comb begin
    active     = period_ended && cfg.enable && (cfg.position_goal != position_ns);
    accel_max  = cfg.acceleration >= cfg.acceleration_limit;
    bypass_pos = (velocity_now >= cfg.velocity_limit) && accel_max;
  end

  // Operand select: position step in M_POS, velocity ramp otherwise
  always_comb begin
    if (state == M_POS) begin
      u_base = position_ns;
      u_x    = cfg.acceleration >> 1;
      u_y    = velocity_now;
      u_up   = cfg.position_goal > position_ns;
      u_goal = cfg.position_goal;
    end else begin
      u_base = velocity_now;
      u_x    = cfg.acceleration;
      u_y    = '0;
      u_up   = cfg.velocity_goal > velocity_now;
      u_goal = cfg.velocity_goal;
    end
  end

  smps_step_unit u_step (
    .base   (u_base),
    .x      (u_x),
    .y      (u_y),
    .up     (u_up),
    .goal   (u_goal),
    .result (u_result)
  );

  // Velocity ramp result
  always_comb begin
    vel_upd = velocity_now;
    vhit    = 1'b0;
    if (velocity_now != cfg.velocity_goal) begin
      vel_upd = accel_max ? cfg.velocity_goal : u_result;
      vhit    = (vel_upd == cfg.velocity_goal);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      M_IDLE: begin
        if (start) begin
          if (active) begin
            state_next = M_POS;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      M_POS: begin
        state_next = M_VEL;
      end
      M_VEL: begin
        state_next = M_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = M_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Motion state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      position_ns  <= POS_RESET;
      velocity_now <= '0;
      pos_hit      <= 1'b0;
      vel_hit      <= 1'b0;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start && !active) begin
            pos_hit <= 1'b0;
            vel_hit <= 1'b0;
          end
        end
        M_POS: begin
          pos_new <= bypass_pos ? cfg.position_goal : u_result;
        end
        M_VEL: begin
          position_ns <= pos_new;
          vel_hit     <= vhit;
          if (pos_new == cfg.position_goal) begin
            velocity_now <= '0;
            pos_hit      <= 1'b1;
          end else begin
            velocity_now <= vel_upd;
            pos_hit      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/smps_divider.sv
// Restoring divider, one quotient bit per cycle: pulse width over divisor.
`timescale 1ns / 1ps

module smps_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [smps_pkg::PW-1:0]   dividend,
  input  logic [smps_pkg::DIVW-1:0] divisor,
  output logic                      done,
  output logic [smps_pkg::PW-1:0]   quotient
);
  import smps_pkg::*;

  localparam int CNT_W = $clog2(PW + 1);

  logic [CNT_W-1:0] count;
  logic [DIVW-1:0]  rem;
  logic [DIVW-1:0]  div;
  logic [DIVW:0]    trial;
  logic             fits;

  // One trial subtract per step; a zero divisor always fits (all ones)
  always_comb begin
    trial = {rem, quotient[PW-1]};
    fits  = trial >= {1'b0, div};
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(PW);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      div      <= divisor;
    end else if (count != '0) begin
      quotient <= {quotient[PW-2:0], fits};
      rem      <= fits ? DIVW'(trial - {1'b0, div}) : trial[DIVW-1:0];
    end
  end

endmodule

FILE: hw/rtl/servo_motion_profile_stepper_top.sv
// Servo motion profile stepper: top level, registers, control and result word.
`timescale 1ns / 1ps

// Each input word (one servo period event) yields one result word: pulse
// width, timer compare count, velocity and one-shot reached flags. An
// accepted word first passes the motion update, which is skipped when no
// update is due, or else runs a position step and a velocity step through
// one shared add-and-clamp unit and then a hand-off to the bit-serial
// divider that forms the compare count. The word then leaves the divider
// and loads the result register. The next word can be accepted in the
// cycle after the load, so a word is not taken before the last one is
// loaded. A result still stalled in the output register delays the load
// by the length of that stall. in_stall is high while a word is being
// worked on. A finished result may wait in the output register while the
// next word is accepted. Registers are to be written only when idle; the
// block itself does not enforce this.
module servo_motion_profile_stepper_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [smps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smps_pkg::PW-1:0]        cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           period_ended,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [smps_pkg::PW-1:0]        pulse_width_ns,
  output logic [smps_pkg::PW-1:0]        compare_count,
  output logic [smps_pkg::PW-1:0]        current_velocity,
  output logic                           position_reached,
  output logic                           velocity_reached
);
  import smps_pkg::*;

  motion_cfg_t     mcfg;
  logic [DIVW-1:0] pulse_divisor;

  top_state_t state;
  top_state_t state_next;

  logic          in_accept;
  logic          div_start;
  logic          load;

  logic          mot_done;
  logic [PW-1:0] mot_position;
  logic [PW-1:0] mot_velocity;
  logic          mot_pos_hit;
  logic          mot_vel_hit;
  logic          div_done;
  logic [PW-1:0] div_quotient;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mcfg.enable             <= 1'b0;
      mcfg.position_goal      <= POS_RESET;
      mcfg.velocity_goal      <= LIMIT_RESET;
      mcfg.acceleration       <= LIMIT_RESET;
      mcfg.velocity_limit     <= LIMIT_RESET;
      mcfg.acceleration_limit <= LIMIT_RESET;
      pulse_divisor           <= DIV_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:      mcfg.enable             <= cfg_data[0];
        REG_POS_GOAL:    mcfg.position_goal      <= cfg_data;
        REG_VEL_GOAL:    mcfg.velocity_goal      <= cfg_data;
        REG_ACCEL:       mcfg.acceleration       <= cfg_data;
        REG_VEL_LIMIT:   mcfg.velocity_limit     <= cfg_data;
        REG_ACCEL_LIMIT: mcfg.acceleration_limit <= cfg_data;
        REG_DIVISOR:     pulse_divisor           <= cfg_data[DIVW-1:0];
        default: begin
        end
      endcase
    end
  end

  smps_motion u_motion (
    .clk          (clk),
    .rst          (rst),
    .start        (in_accept),
    .period_ended (period_ended),
    .cfg          (mcfg),
    .done         (mot_done),
    .position_ns  (mot_position),
    .velocity_now (mot_velocity),
    .pos_hit      (mot_pos_hit),
    .vel_hit      (mot_vel_hit)
  );

  smps_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mot_position),
    .divisor  (pulse_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Control sequence and handshake
  always_comb begin
    state_next = state;
    in_stall   = (state != T_IDLE);
    in_accept  = in_valid && (state == T_IDLE);
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state)
      T_IDLE: begin
        if (in_valid) begin
          state_next = T_MOTION;
        end
      end
      T_MOTION: begin
        if (mot_done) begin
          div_start  = 1'b1;
          state_next = T_DIV;
        end
      end
      T_DIV: begin
        if (div_done) begin
          state_next = T_LOAD;
        end
      end
      T_LOAD: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pulse_width_ns   <= mot_position;
      compare_count    <= div_quotient;
      current_velocity <= mot_velocity;
      position_reached <= mot_pos_hit;
      velocity_reached <= mot_vel_hit;
    end
  end

endmodule
